>>> hdl/bols_pkg.sv
`default_nettype none
package bols_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int IDX_W   = 9;
  localparam int CNT_W   = 9;

  typedef logic [1:0]                opcode_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          position_t;
  typedef logic signed [IDX_W-1:0]   found_index_t;
  typedef logic [CNT_W-1:0]          count_t;

  localparam opcode_t OP_APPEND  = 2'd0;
  localparam opcode_t OP_PREPEND = 2'd1;
  localparam opcode_t OP_DELETE  = 2'd2;
  localparam opcode_t OP_FIND    = 2'd3;

  localparam found_index_t NOT_FOUND = '1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the incoming word
    logic start;   // set up the walk pointers
    logic issue;   // read the entry at the walk pointer and step it
    logic proc;    // act on the entry read in the previous cycle
    logic finish;  // apply the final update and load the result register
  } bols_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip_walk;   // no walk over the store is needed
    logic last_issue;  // walk pointer sits on the last entry to read
    logic match;       // entry read last cycle equals the search value
    logic out_free;    // result register can take a new word
  } bols_sts_t;

endpackage
`default_nettype wire

>>> hdl/bols_if.sv
`default_nettype none
interface bols_in_if import bols_pkg::*; ();
  logic      valid;
  logic      ready;
  opcode_t   opcode;
  value_t    value;
  position_t position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface bols_out_if import bols_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         ok;
  found_index_t found_index;
  count_t       count;

  modport source (output valid, ok, found_index, count, input ready);
  modport sink   (input valid, ok, found_index, count, output ready);
endinterface
`default_nettype wire

>>> hdl/bounded_ordered_list_store.sv
// Bounded ordered list store: a list of signed 32-bit values, at most CAPACITY long.
// in_ch carries one word per operation: opcode (append, prepend, delete at
// position, find value), value and position. out_ch returns exactly one word
// per operation: ok, found_index (-1 unless find hit) and the count afterward.
// Both channels use valid/ready; a word moves when both are high.
// out_ch.valid rises with the result register load. Work per operation,
// n = count before the operation:
//   append, full store, bad delete position, any op on an empty list: no walk
//   prepend on a non-empty list: walk all n entries, each moves back one place
//   delete at p, p below n - 1: walk the entries behind p, each moves forward
//   delete of the last entry: no walk
//   find: walk up to the first hit, or over all n entries on a miss
// The single-port-read store sets the pace: one entry is read per cycle and
// written back the next. One operation is in flight at a time; in_ch.ready is
// high only while the block is idle, from each result load until a word is
// taken, and the next word is taken while the last result still waits on
// out_ch. If out_ch stalls, the block holds the finished result and waits
// before loading the result register again, so the stall delays the result.
// Reset (rst_n low, synchronous) empties the list; stored values need no clear.
`default_nettype none
module bounded_ordered_list_store import bols_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  bols_in_if.sink  in_ch,
  bols_out_if.source out_ch
);

  bols_cmd_t cmd;
  bols_sts_t sts;

  // sequencer: walks the store one entry per cycle
  bols_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, count, walk pointers and result register
  bols_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_value        (in_ch.value),
    .in_position     (in_ch.position),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_ok          (out_ch.ok),
    .out_found_index (out_ch.found_index),
    .out_count       (out_ch.count)
  );

endmodule
`default_nettype wire

>>> hdl/bols_ram.sv
`default_nettype none
module bols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/bols_ctrl.sv
`default_nettype none
module bols_ctrl import bols_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bols_sts_t sts,
  output bols_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.skip_walk) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.proc = 1'b1;
        if (sts.match) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (sts.last_issue) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cmd.proc  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bols_dp.sv
`default_nettype none
module bols_dp import bols_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bols_cmd_t    cmd,
  output bols_sts_t         sts,
  input  wire opcode_t      in_opcode,
  input  wire value_t       in_value,
  input  wire position_t    in_position,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_ok,
  output found_index_t      out_found_index,
  output count_t            out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = CW + POS_W;

  // latched item
  opcode_t   op_r;
  value_t    value_r;
  position_t pos_r;

  logic [CW-1:0] count_r, count_fin;
  logic [AW-1:0] idx_r, end_r, pend_addr_r, hit_idx_r;
  logic          down_r, pend_r, hit_r;

  logic         out_valid_r, ok_r;
  found_index_t fidx_r;
  count_t       cnt_out_r;

  logic          full, empty, del_bad, del_last, ok_fin;
  logic [LW-1:0] pos_w, cnt_w, pos_p1;
  logic [CW-1:0] cnt_m1;
  logic [AW+IDX_W-1:0] hit_ext;
  logic [CW+CNT_W-1:0] cnt_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  value_t        ram_wdata;
  value_t        ram_rdata;

  bols_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign pos_w    = {{CW{1'b0}}, pos_r};
  assign cnt_w    = {{POS_W{1'b0}}, count_r};
  assign pos_p1   = pos_w + LW'(1);
  assign cnt_m1   = count_r - CW'(1);
  assign del_bad  = (pos_w >= cnt_w);
  assign del_last = (pos_p1 == cnt_w);

  always_comb begin
    sts = '0;
    case (op_r)
      OP_APPEND:  sts.skip_walk = 1'b1;
      OP_PREPEND: sts.skip_walk = full || empty;
      OP_DELETE:  sts.skip_walk = del_bad || del_last;
      default:    sts.skip_walk = empty;
    endcase
    sts.last_issue = (idx_r == end_r);
    sts.match      = pend_r && (op_r == OP_FIND) && (ram_rdata == value_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // memory write: shift moves during the walk, the new entry at the end
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if (cmd.proc && pend_r && (op_r == OP_PREPEND)) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r + AW'(1);
    end else if (cmd.proc && pend_r && (op_r == OP_DELETE)) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r - AW'(1);
    end else if (cmd.finish && !full && (op_r == OP_APPEND)) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = value_r;
    end else if (cmd.finish && !full && (op_r == OP_PREPEND)) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = value_r;
    end
  end

  always_comb begin
    ok_fin    = 1'b0;
    count_fin = count_r;
    case (op_r)
      OP_APPEND, OP_PREPEND: begin
        ok_fin = !full;
        if (!full) begin
          count_fin = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        ok_fin = !del_bad;
        if (!del_bad) begin
          count_fin = cnt_m1;
        end
      end
      default: begin
        ok_fin = hit_r;
      end
    endcase
  end

  assign hit_ext = {{IDX_W{1'b0}}, hit_idx_r};
  assign cnt_ext = {{CNT_W{1'b0}}, count_fin};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (cmd.start) begin
      down_r <= (op_r == OP_PREPEND);
      if (op_r == OP_PREPEND) begin
        idx_r <= cnt_m1[AW-1:0];
        end_r <= '0;
      end else begin
        idx_r <= (op_r == OP_DELETE) ? pos_p1[AW-1:0] : '0;
        end_r <= cnt_m1[AW-1:0];
      end
    end else if (cmd.issue) begin
      idx_r <= down_r ? idx_r - AW'(1) : idx_r + AW'(1);
    end
    if (cmd.issue) begin
      pend_addr_r <= idx_r;
    end
    if (cmd.proc && sts.match) begin
      hit_idx_r <= pend_addr_r;
    end
    if (cmd.finish) begin
      ok_r      <= ok_fin;
      fidx_r    <= (op_r == OP_FIND && hit_r) ? found_index_t'(hit_ext[IDX_W-1:0]) : NOT_FOUND;
      cnt_out_r <= cnt_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.issue;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmd.proc && sts.match) begin
        hit_r <= 1'b1;
      end
      if (cmd.finish) begin
        count_r     <= count_fin;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_found_index = fidx_r;
  assign out_count       = cnt_out_r;

endmodule
`default_nettype wire
